// File: src/sctlv_pkg.sv
`default_nettype none

package sctlv_pkg;

  // Default for the length-limit parameter of the top level.
  localparam int LENGTH_BITS_DEFAULT = 16;

  // Configuration port sizes.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_TLV_FORMAT       = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALUE_LENGTH = 1'd1;

  // Register reset values.
  localparam logic [1:0]  TLV_FORMAT_RESET       = 2'd1;
  localparam logic [15:0] MAX_VALUE_LENGTH_RESET = 16'd255;

  // Format codes held in tlv_format.
  localparam logic [1:0] FMT_SIMPLE  = 2'd0;
  localparam logic [1:0] FMT_BER     = 2'd1;
  localparam logic [1:0] FMT_COMPACT = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd2;
  localparam logic [1:0] ERR_BAD_FORM  = 2'd3;

  // Byte constants of the formats.
  localparam logic [7:0] COMPACT_TAG_BASE = 8'h40;
  localparam logic [7:0] SIMPLE_LEN_ESC   = 8'hff;
  localparam logic [7:0] LOW_SEVEN_MASK   = 8'h7f;
  localparam logic [3:0] NIBBLE_MASK      = 4'hf;
  localparam logic [4:0] BER_TAG_ESC      = 5'h1f;
  localparam logic [7:0] BER_LONG_BASE    = 8'h80;
  localparam logic [7:0] BER_LONG_MAX     = 8'h84;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_TAG1,
    PH_TAG2,
    PH_TAG3,
    PH_LEN1,
    PH_LENX,
    PH_VALUE
  } phase_t;

  // What a byte does to the object in progress.
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_MORE,
    ACT_FINISH,
    ACT_FAIL
  } action_t;

  // Input word.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_end;
  } tlv_in_t;

  // Result word.
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [13:0] tag_value;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [15:0] value_length;
    logic [7:0]  value_byte;
    logic        object_end;
    logic [1:0]  error_code;
  } tlv_out_t;

  // Configuration register contents.
  typedef struct packed {
    logic [1:0]  tlv_format;
    logic [15:0] max_value_length;
  } tlv_cfg_t;

endpackage

`default_nettype wire

// File: src/sctlv_cfg.sv
`default_nettype none

module sctlv_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [sctlv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [sctlv_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sctlv_pkg::tlv_cfg_t                     cfg
);
  import sctlv_pkg::*;

  // Register file: format and length limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tlv_format       <= TLV_FORMAT_RESET;
      cfg.max_value_length <= MAX_VALUE_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TLV_FORMAT:       cfg.tlv_format       <= cfg_data[1:0];
        REG_MAX_VALUE_LENGTH: cfg.max_value_length <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/sctlv_decode.sv
`default_nettype none

module sctlv_decode #(
  parameter int LENGTH_BITS = sctlv_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  sctlv_pkg::tlv_in_t        word,
  input  sctlv_pkg::tlv_cfg_t       cfg,
  output logic                      res_valid,
  output sctlv_pkg::tlv_out_t       res
);
  import sctlv_pkg::*;

  // Largest length that the length field can carry.
  localparam logic [32:0] LenCap = (33'd1 << LENGTH_BITS) - 33'd1;

  // Parser state.
  phase_t      phase;
  logic [13:0] tag;
  logic [1:0]  cls;
  logic        cons;
  logic [31:0] len;
  logic [2:0]  len_left;
  logic [15:0] val_left;
  logic        skip;
  logic [1:0]  fmt;

  phase_t      phase_next;
  logic [13:0] tag_next;
  logic [1:0]  cls_next;
  logic        cons_next;
  logic [31:0] len_next;
  logic [2:0]  len_left_next;
  logic [15:0] val_left_next;
  logic        skip_next;
  logic [1:0]  fmt_next;

  // Effective length limit: the smaller of the register and the field cap.
  logic [32:0] limit;
  assign limit = ({17'd0, cfg.max_value_length} < LenCap) ?
                 {17'd0, cfg.max_value_length} : LenCap;

  // One byte of parsing: first the field updates and an action, then the
  // common handling of that action.
  always_comb begin
    logic [7:0]  b;
    logic        last;
    action_t     act;
    logic [1:0]  code;
    logic [15:0] len_sat;

    b       = word.in_byte;
    last    = word.buffer_end;
    act     = ACT_NONE;
    code    = ERR_NONE;
    len_sat = '0;

    phase_next    = phase;
    tag_next      = tag;
    cls_next      = cls;
    cons_next     = cons;
    len_next      = len;
    len_left_next = len_left;
    val_left_next = val_left;
    skip_next     = skip;
    fmt_next      = fmt;

    res_valid        = 1'b0;
    res.item_kind    = KIND_HEADER;
    res.tag_value    = '0;
    res.tag_class    = '0;
    res.constructed  = 1'b0;
    res.value_length = '0;
    res.value_byte   = '0;
    res.object_end   = 1'b0;
    res.error_code   = ERR_NONE;

    if (skip) begin
      // Dropping bytes after an error until the buffer ends.
      if (last) begin
        skip_next  = 1'b0;
        phase_next = PH_TAG1;
      end
    end else begin
      unique case (phase)
        PH_TAG1: begin
          tag_next      = '0;
          cls_next      = '0;
          cons_next     = 1'b0;
          len_next      = '0;
          len_left_next = '0;
          val_left_next = '0;
          fmt_next      = cfg.tlv_format;
          unique case (cfg.tlv_format)
            FMT_SIMPLE: begin
              tag_next   = {6'd0, b};
              phase_next = PH_LEN1;
              act        = ACT_MORE;
            end
            FMT_BER: begin
              cls_next   = b[7:6];
              cons_next  = b[5];
              tag_next   = {9'd0, b[4:0]};
              phase_next = (b[4:0] == BER_TAG_ESC) ? PH_TAG2 : PH_LEN1;
              act        = ACT_MORE;
            end
            FMT_COMPACT: begin
              tag_next = {6'd0, COMPACT_TAG_BASE | {4'd0, b[7:4]}};
              len_next = {28'd0, b[3:0] & NIBBLE_MASK};
              act      = ACT_FINISH;
            end
            default: begin
              act  = ACT_FAIL;
              code = ERR_BAD_FORM;
            end
          endcase
        end
        PH_TAG2: begin
          if (b[7]) begin
            tag_next   = {6'd0, b & LOW_SEVEN_MASK};
            phase_next = PH_TAG3;
          end else begin
            tag_next   = {6'd0, b};
            phase_next = PH_LEN1;
          end
          act = ACT_MORE;
        end
        PH_TAG3: begin
          tag_next   = {tag[6:0], b[6:0]};
          phase_next = PH_LEN1;
          act        = ACT_MORE;
        end
        PH_LEN1: begin
          if (fmt == FMT_SIMPLE) begin
            if (b == SIMPLE_LEN_ESC) begin
              len_left_next = 3'd2;
              phase_next    = PH_LENX;
              act           = ACT_MORE;
            end else begin
              len_next = {24'd0, b};
              act      = ACT_FINISH;
            end
          end else if (b < BER_LONG_BASE) begin
            len_next = {24'd0, b};
            act      = ACT_FINISH;
          end else if (b == BER_LONG_BASE || b > BER_LONG_MAX) begin
            act  = ACT_FAIL;
            code = ERR_BAD_FORM;
          end else begin
            len_left_next = b[2:0];
            phase_next    = PH_LENX;
            act           = ACT_MORE;
          end
        end
        PH_LENX: begin
          len_next      = {len[23:0], b};
          len_left_next = len_left - 3'd1;
          act           = (len_left_next == 3'd0) ? ACT_FINISH : ACT_MORE;
        end
        PH_VALUE: begin
          val_left_next    = val_left - 16'd1;
          res.item_kind    = KIND_VALUE;
          res.value_length = len[15:0];
          res.value_byte   = b;
          if (val_left_next == 16'd0) begin
            res_valid      = 1'b1;
            res.object_end = 1'b1;
            phase_next     = PH_TAG1;
          end else if (last) begin
            act  = ACT_FAIL;
            code = ERR_TRUNCATED;
          end else begin
            res_valid = 1'b1;
          end
        end
        default: begin
          phase_next = PH_TAG1;
        end
      endcase

      // A byte that leaves the object open truncates it at buffer end.
      if (act == ACT_MORE && last) begin
        act  = ACT_FAIL;
        code = ERR_TRUNCATED;
      end

      // Length known: check the limit, then emit the header (or a truncation error at buffer end).
      if (act == ACT_FINISH) begin
        if ({1'b0, len_next} > limit) begin
          act  = ACT_FAIL;
          code = ERR_TOO_LONG;
        end else if (len_next == 32'd0) begin
          res_valid        = 1'b1;
          res.item_kind    = KIND_HEADER;
          res.value_length = '0;
          res.value_byte   = '0;
          res.object_end   = 1'b1;
          phase_next       = PH_TAG1;
        end else if (last) begin
          act  = ACT_FAIL;
          code = ERR_TRUNCATED;
        end else begin
          res_valid        = 1'b1;
          res.item_kind    = KIND_HEADER;
          res.value_length = len_next[15:0];
          res.value_byte   = '0;
          res.object_end   = 1'b0;
          val_left_next    = len_next[15:0];
          phase_next       = PH_VALUE;
        end
      end

      // Error result; skip the rest of the buffer unless it ends here.
      len_sat = (|len_next[31:16]) ? 16'hffff : len_next[15:0];
      if (act == ACT_FAIL) begin
        res_valid        = 1'b1;
        res.item_kind    = KIND_ERROR;
        res.value_length = (code == ERR_TOO_LONG) ? len_sat : 16'd0;
        res.value_byte   = '0;
        res.object_end   = 1'b1;
        res.error_code   = code;
        phase_next       = PH_TAG1;
        skip_next        = !last;
      end

      res.tag_value   = tag_next;
      res.tag_class   = cls_next;
      res.constructed = cons_next;
    end
  end

  // State registers, advanced once per parsed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_TAG1;
      tag      <= '0;
      cls      <= '0;
      cons     <= 1'b0;
      len      <= '0;
      len_left <= '0;
      val_left <= '0;
      skip     <= 1'b0;
      fmt      <= FMT_SIMPLE;
    end else if (step) begin
      phase    <= phase_next;
      tag      <= tag_next;
      cls      <= cls_next;
      cons     <= cons_next;
      len      <= len_next;
      len_left <= len_left_next;
      val_left <= val_left_next;
      skip     <= skip_next;
      fmt      <= fmt_next;
    end
  end

endmodule

`default_nettype wire

// File: src/smart_card_tlv_parser.sv
`default_nettype none

// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall  in_data  (in_byte, buffer_end)
// output    out        out_valid/ out_stall out_data (header, value byte or error)
// config    in         cfg_write            cfg_index, cfg_data
//
// One byte per cycle is sustained while the output does not stall: a byte
// sits in the input register while the parser state and the result
// register are updated, and its result is then held in the result register.
// Reset is synchronous; it restores the register defaults and the parser
// to the start of an object. A stall on the output holds the result and
// the byte under parse; the input stalls only when both are occupied.

module smart_card_tlv_parser #(
  parameter int LENGTH_BITS = sctlv_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  sctlv_pkg::tlv_in_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output sctlv_pkg::tlv_out_t                    out_data,
  input  wire logic                              cfg_write,
  input  wire logic [sctlv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sctlv_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sctlv_pkg::*;

  tlv_cfg_t cfg;
  tlv_in_t  s1_data;
  logic     s1_valid;
  logic     out_ready;
  logic     advance;
  logic     res_valid;
  tlv_out_t res;

  sctlv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: the held byte moves on whenever the result register is free.
  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  sctlv_decode #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .word      (s1_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// File: bench/tlv_result_checker.sv
`timescale 1ns / 100ps

// Watches the byte and result channels of the TLV parser, predicts every
// result word from the accepted bytes and compares it field by field.
module tlv_result_checker
  import sctlv_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic                    in_stall,
  input  tlv_in_t                      in_data,
  input  wire logic                    out_valid,
  input  wire logic                    out_stall,
  input  tlv_out_t                     out_data,
  input  wire logic                    cfg_write,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  output int                           fail_count,
  output int                           pending
);

  localparam longint unsigned LENGTH_CAP = (64'd1 << LENGTH_BITS_DEFAULT) - 64'd1;
  localparam int MAX_REPORTS = 50;

  // Configuration as the parser sees it.
  logic [1:0]  fmt_reg;
  logic [15:0] max_len;

  // Parser state of the prediction.
  phase_t      phase;
  logic [13:0] tag_acc;
  logic [1:0]  cls;
  logic        cons;
  logic [31:0] len_acc;
  logic [2:0]  len_bytes;
  logic [15:0] value_left;
  logic        skipping;
  logic [1:0]  obj_fmt;

  tlv_out_t expected_words[$];
  int       reports;

  initial begin
    fail_count = 0;
    pending = 0;
    reports = 0;
  end

  // Builds a result word from the object decoded so far.
  function automatic tlv_out_t make_word(logic [1:0] kind, logic [31:0] vlen,
                                         logic [7:0] vbyte, logic oend,
                                         logic [1:0] code);
    tlv_out_t w;
    w.item_kind    = kind;
    w.tag_value    = tag_acc;
    w.tag_class    = cls;
    w.constructed  = cons;
    w.value_length = (vlen > 32'hffff) ? 16'hffff : vlen[15:0];
    w.value_byte   = vbyte;
    w.object_end   = oend;
    w.error_code   = code;
    return w;
  endfunction

  // An error ends the object; unless the buffer ends here, the rest of it is skipped.
  function automatic tlv_out_t error_word(logic [1:0] code, logic last);
    tlv_out_t w;
    w = make_word(KIND_ERROR, (code == ERR_TOO_LONG) ? len_acc : 32'd0, 8'd0, 1'b1, code);
    phase = PH_TAG1;
    skipping = !last;
    return w;
  endfunction

  // The length is complete: check it against the limit and emit the header.
  function automatic tlv_out_t length_word(logic last);
    longint unsigned lim;
    tlv_out_t w;
    lim = (64'(max_len) < LENGTH_CAP) ? 64'(max_len) : LENGTH_CAP;
    if (64'(len_acc) > lim) begin
      return error_word(ERR_TOO_LONG, last);
    end
    if (len_acc == 32'd0) begin
      w = make_word(KIND_HEADER, 32'd0, 8'd0, 1'b1, ERR_NONE);
      phase = PH_TAG1;
      return w;
    end
    if (last) begin
      return error_word(ERR_TRUNCATED, 1'b1);
    end
    w = make_word(KIND_HEADER, len_acc, 8'd0, 1'b0, ERR_NONE);
    value_left = len_acc[15:0];
    phase = PH_VALUE;
    return w;
  endfunction

  // Advances the predicted parser by one byte; returns 1 when a result is due.
  function automatic bit parse_byte(logic [7:0] b, logic last, output tlv_out_t w);
    w = '0;
    if (skipping) begin
      if (last) begin
        skipping = 1'b0;
        phase = PH_TAG1;
      end
      return 1'b0;
    end
    case (phase)
      PH_TAG1: begin
        tag_acc = '0;
        cls = '0;
        cons = 1'b0;
        len_acc = '0;
        len_bytes = '0;
        value_left = '0;
        obj_fmt = fmt_reg;
        case (obj_fmt)
          FMT_SIMPLE: begin
            tag_acc = {6'd0, b};
            phase = PH_LEN1;
          end
          FMT_BER: begin
            cls = b[7:6];
            cons = b[5];
            tag_acc = {9'd0, b[4:0]};
            phase = (b[4:0] == BER_TAG_ESC) ? PH_TAG2 : PH_LEN1;
          end
          FMT_COMPACT: begin
            tag_acc = {6'd0, COMPACT_TAG_BASE | {4'd0, b[7:4]}};
            len_acc = {28'd0, b[3:0] & NIBBLE_MASK};
            w = length_word(last);
            return 1'b1;
          end
          default: begin
            w = error_word(ERR_BAD_FORM, last);
            return 1'b1;
          end
        endcase
      end
      PH_TAG2: begin
        if (b[7]) begin
          tag_acc = {7'd0, b[6:0]};
          phase = PH_TAG3;
        end else begin
          tag_acc = {6'd0, b};
          phase = PH_LEN1;
        end
      end
      PH_TAG3: begin
        tag_acc = {tag_acc[6:0], b[6:0]};
        phase = PH_LEN1;
      end
      PH_LEN1: begin
        if (obj_fmt == FMT_SIMPLE) begin
          if (b == SIMPLE_LEN_ESC) begin
            len_bytes = 3'd2;
            phase = PH_LENX;
          end else begin
            len_acc = {24'd0, b};
            w = length_word(last);
            return 1'b1;
          end
        end else if (b < BER_LONG_BASE) begin
          len_acc = {24'd0, b};
          w = length_word(last);
          return 1'b1;
        end else if (b == BER_LONG_BASE || b > BER_LONG_MAX) begin
          w = error_word(ERR_BAD_FORM, last);
          return 1'b1;
        end else begin
          len_bytes = 3'(b - BER_LONG_BASE);
          phase = PH_LENX;
        end
      end
      PH_LENX: begin
        len_acc = {len_acc[23:0], b};
        len_bytes = len_bytes - 3'd1;
        if (len_bytes == 3'd0) begin
          w = length_word(last);
          return 1'b1;
        end
      end
      PH_VALUE: begin
        value_left = value_left - 16'd1;
        if (value_left == 16'd0) begin
          w = make_word(KIND_VALUE, len_acc, b, 1'b1, ERR_NONE);
          phase = PH_TAG1;
          return 1'b1;
        end
        if (last) begin
          w = error_word(ERR_TRUNCATED, 1'b1);
          return 1'b1;
        end
        w = make_word(KIND_VALUE, len_acc, b, 1'b0, ERR_NONE);
        return 1'b1;
      end
      default: begin
        phase = PH_TAG1;
        return 1'b0;
      end
    endcase
    // The byte was taken but the object is not complete yet.
    if (last) begin
      w = error_word(ERR_TRUNCATED, 1'b1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Reports one field that differs; returns 1 when it matches.
  function automatic bit field_ok(string name, int unsigned want, int unsigned got);
    if (want == got) begin
      return 1'b1;
    end
    if (reports < MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      reports++;
    end
    return 1'b0;
  endfunction

  // Prediction on each accepted byte, comparison on each accepted result word.
  always @(posedge clk) begin
    tlv_out_t w;
    tlv_out_t want;
    bit ok;
    if (rst) begin
      fmt_reg = TLV_FORMAT_RESET;
      max_len = MAX_VALUE_LENGTH_RESET;
      phase = PH_TAG1;
      tag_acc = '0;
      cls = '0;
      cons = 1'b0;
      len_acc = '0;
      len_bytes = '0;
      value_left = '0;
      skipping = 1'b0;
      obj_fmt = FMT_SIMPLE;
      expected_words.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TLV_FORMAT:       fmt_reg = cfg_data[1:0];
          REG_MAX_VALUE_LENGTH: max_len = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (parse_byte(in_data.in_byte, in_data.buffer_end, w)) begin
          expected_words.push_back(w);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (reports < MAX_REPORTS) begin
            $display("%0t: result word with none expected, actual %0h", $time, out_data);
            reports++;
          end
        end else begin
          want = expected_words.pop_front();
          ok = 1'b1;
          ok = ok & field_ok("item_kind", want.item_kind, out_data.item_kind);
          ok = ok & field_ok("tag_value", want.tag_value, out_data.tag_value);
          ok = ok & field_ok("tag_class", want.tag_class, out_data.tag_class);
          ok = ok & field_ok("constructed", want.constructed, out_data.constructed);
          ok = ok & field_ok("value_length", want.value_length, out_data.value_length);
          ok = ok & field_ok("value_byte", want.value_byte, out_data.value_byte);
          ok = ok & field_ok("object_end", want.object_end, out_data.object_end);
          ok = ok & field_ok("error_code", want.error_code, out_data.error_code);
          if (!ok) begin
            fail_count++;
          end
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// File: bench/smart_card_tlv_parser_test.sv
`timescale 1ns / 100ps

// Drives byte buffers of every format into the TLV parser under random flow
// control; the checker beside the parser predicts and compares the results.
module smart_card_tlv_parser_test;
  import sctlv_pkg::*;

  localparam logic [1:0] FMT_UNKNOWN = 2'd3;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 195;
  localparam int SETTLE_CYCLES = 4;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY, STALL_BLOCKS} stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  tlv_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  tlv_out_t               out_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_TLV_FORMAT;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     fail_count;
  int                     pending;

  tlv_in_t     buf_words[$];
  int          items_sent = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  smart_card_tlv_parser DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  tlv_result_checker result_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // The receiver switches at random between stall patterns.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 4));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
      STALL_HEAVY: out_stall <= (stall_left % 4 != 0);
      default:     out_stall <= (stall_left % 32 < 12);
    endcase
  end

  // Sends one word in bursts with gaps; entered and left at a falling edge.
  task automatic send_word(tlv_in_t w);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 120);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
      end
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_data = w;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic add_byte(logic [7:0] b);
    tlv_in_t w;
    w.in_byte = b;
    w.buffer_end = 1'b0;
    buf_words.push_back(w);
  endtask

  // Marks the last byte as the end of the buffer and sends the buffer.
  task automatic flush_buffer();
    buf_words[buf_words.size() - 1].buffer_end = 1'b1;
    foreach (buf_words[i]) send_word(buf_words[i]);
    buf_words.delete();
    in_valid = 1'b0;
  endtask

  // Waits until every predicted result has come out and the pipeline drained.
  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Mostly short lengths, with the limit, just past it and huge ones mixed in.
  function automatic int unsigned pick_length(int unsigned lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 6);
    if (r < 70) return $urandom_range(7, 24);
    if (r < 80) return lim;
    if (r < 90) return lim + 1 + $urandom_range(0, 3);
    if (r < 95) return $urandom_range(25, 300);
    return $urandom;
  endfunction

  // Appends one object in the given format; sets cut when the buffer must end
  // inside the value because the length is too long to send in full.
  task automatic add_object(logic [1:0] fmt, int unsigned lim, output bit cut);
    int unsigned len;
    int          nbytes;
    logic [7:0]  b;
    cut = 1'b0;
    len = pick_length(lim);
    case (fmt)
      FMT_SIMPLE: begin
        add_byte(8'($urandom));
        if (len < 255 && $urandom_range(0, 3) != 0) begin
          add_byte(8'(len));
        end else begin
          len = len & 32'hffff;
          add_byte(SIMPLE_LEN_ESC);
          add_byte(8'(len >> 8));
          add_byte(8'(len));
        end
      end
      FMT_BER: begin
        b = 8'($urandom);
        if ($urandom_range(0, 2) == 0) b[4:0] = BER_TAG_ESC;
        add_byte(b);
        if (b[4:0] == BER_TAG_ESC) begin
          b = 8'($urandom);
          add_byte(b);
          if (b[7]) add_byte(8'($urandom));
        end
        if ($urandom_range(0, 9) == 0) begin
          // Reserved length forms; the rest of the buffer is skipped.
          add_byte($urandom_range(0, 1) ? BER_LONG_BASE
                                        : 8'($urandom_range(BER_LONG_MAX + 1, 255)));
          return;
        end
        if (len < 128 && $urandom_range(0, 9) < 6) begin
          add_byte(8'(len));
        end else begin
          if (len > 32'hffffff) nbytes = 4;
          else if (len > 32'hffff) nbytes = 3;
          else if (len > 32'hff) nbytes = 2;
          else nbytes = 1;
          nbytes = $urandom_range(nbytes, 4);
          add_byte(BER_LONG_BASE + 8'(nbytes));
          for (int i = nbytes; i > 0; i--) add_byte(8'(len >> (8 * (i - 1))));
        end
      end
      FMT_COMPACT: begin
        len = len & 32'hf;
        add_byte({4'($urandom), len[3:0]});
      end
      default: begin
        add_byte(8'($urandom));
        return;
      end
    endcase
    if (len > lim) return;
    if (len > 48) begin
      repeat (3) add_byte(8'($urandom));
      cut = 1'b1;
    end else begin
      repeat (len) add_byte(8'($urandom));
    end
  endtask

  // One buffer: mostly well-formed objects, some cut short, some plain noise.
  task automatic send_buffer(logic [1:0] fmt, int unsigned lim);
    int      nobj;
    int      keep;
    int      r;
    bit      cut;
    tlv_in_t w;
    nobj = $urandom_range(1, 4);
    cut = 1'b0;
    for (int k = 0; k < nobj && !cut; k++) add_object(fmt, lim, cut);
    r = $urandom_range(0, 99);
    if (r >= 80 && r < 90 && buf_words.size() > 1) begin
      keep = $urandom_range(1, buf_words.size() - 1);
      while (buf_words.size() > keep) void'(buf_words.pop_back());
    end else if (r >= 90) begin
      buf_words.delete();
      repeat ($urandom_range(1, 10)) begin
        w.in_byte = 8'($urandom);
        w.buffer_end = ($urandom_range(0, 5) == 0);
        buf_words.push_back(w);
      end
    end
    flush_buffer();
  endtask

  initial begin
    logic [1:0]  fmt;
    logic [15:0] lim;
    int          phase_start;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed buffers in the reset setting (BER-TLV, limit 255).
    // Empty object with all-zero bytes.
    add_byte(8'h00); add_byte(8'h00); flush_buffer();
    // Three-byte tag with every bit set.
    add_byte(8'hff); add_byte(8'hff); add_byte(8'hff); add_byte(8'h00); flush_buffer();
    // Two-byte long-form length and one value byte.
    add_byte(8'h82); add_byte(8'h82); add_byte(8'h00); add_byte(8'h01); add_byte(8'hff);
    flush_buffer();
    // Reserved length form, then a skipped byte up to the buffer end.
    add_byte(8'h01); add_byte(8'h80); add_byte(8'h33); flush_buffer();
    // Length over the limit on the byte that also ends the buffer.
    add_byte(8'h01); add_byte(8'h82); add_byte(8'h01); add_byte(8'h00); flush_buffer();
    // Buffer ends inside the value.
    add_byte(8'h02); add_byte(8'h02); add_byte(8'h11); flush_buffer();

    // Simple-TLV with the escaped two-byte length.
    wait_idle();
    write_reg(REG_TLV_FORMAT, {14'd0, FMT_SIMPLE});
    add_byte(8'h12); add_byte(8'hff); add_byte(8'h00); add_byte(8'h01); add_byte(8'h5a);
    flush_buffer();
    // Compact TLV with the highest tag nibble.
    wait_idle();
    write_reg(REG_TLV_FORMAT, {14'd0, FMT_COMPACT});
    add_byte(8'hf1); add_byte(8'ha5); flush_buffer();
    // Unknown format rejects the first byte of an object.
    wait_idle();
    write_reg(REG_TLV_FORMAT, {14'd0, FMT_UNKNOWN});
    add_byte(8'h00); flush_buffer();

    // Random buffers over a range of formats and length limits.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin fmt = FMT_BER;     lim = 16'd255;   end
        1: begin fmt = FMT_SIMPLE;  lim = 16'd0;     end
        2: begin fmt = FMT_COMPACT; lim = 16'hffff;  end
        3: begin fmt = FMT_BER;     lim = 16'hffff;  end
        4: begin fmt = FMT_SIMPLE;  lim = 16'd12;    end
        5: begin fmt = FMT_COMPACT; lim = 16'd0;     end
        6: begin fmt = FMT_UNKNOWN; lim = 16'd255;   end
        7: begin fmt = FMT_BER;     lim = 16'd5;     end
        8: begin fmt = FMT_SIMPLE;  lim = 16'hffff;  end
        default: begin fmt = FMT_COMPACT; lim = 16'($urandom_range(1, 14)); end
      endcase
      wait_idle();
      write_reg(REG_TLV_FORMAT, {14'd0, fmt});
      write_reg(REG_MAX_VALUE_LENGTH, lim);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_buffer(fmt, lim);
        if ($urandom_range(0, 39) == 0) wait_idle();
      end
    end

    // Drain and give the verdict.
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
